// ===== design/bma_pkg.sv =====
package bma_pkg;

  // Pool geometry. Both must be powers of two: block and percent math use shifts.
  localparam int NUM_BLOCKS  = 1024;
  localparam int BLOCK_BYTES = 32;

  localparam int BLK_W       = $clog2(NUM_BLOCKS);
  localparam int CNT_W       = $clog2(NUM_BLOCKS + 1);
  localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
  localparam int POOL_BYTES  = NUM_BLOCKS * BLOCK_BYTES;

  localparam int BYTES_W  = 16;
  localparam int OFS_W    = 15;
  localparam int PCT_W    = 7;
  localparam int PCT_FULL = 100;

  typedef enum logic [1:0] {
    STS_OK     = 2'd0,
    STS_NO_RUN = 2'd1,
    STS_ZERO   = 2'd2,
    STS_RANGE  = 2'd3
  } status_t;

  localparam logic MODE_FREE = 1'b1;

  // Result handed from the sequencer to the output stage.
  typedef struct packed {
    status_t           status;
    logic [OFS_W-1:0]  granted_offset;
    logic [CNT_W-1:0]  used_blocks;
  } rsp_t;

endpackage

// ===== design/bma_in_if.sv =====
interface bma_in_if
  import bma_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               mode;
  logic [BYTES_W-1:0] request_bytes;
  logic [BYTES_W-1:0] release_offset;

  modport source (output valid, output mode, output request_bytes, output release_offset,
                  input ready);
  modport sink   (input valid, input mode, input request_bytes, input release_offset,
                  output ready);
endinterface

// ===== design/bma_out_if.sv =====
interface bma_out_if
  import bma_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [OFS_W-1:0] granted_offset;
  logic [PCT_W-1:0] usage_percent;

  modport source (output valid, output status, output granted_offset, output usage_percent,
                  input ready);
  modport sink   (input valid, input status, input granted_offset, input usage_percent,
                  output ready);
endinterface

// ===== design/bma_result_reg.sv =====
module bma_result_reg
  import bma_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  rsp_t          rsp,
  output logic          can_load,
  bma_out_if.source     out_bus
);

  logic                 valid_r;
  logic [1:0]           status_r;
  logic [OFS_W-1:0]     granted_r;
  logic [PCT_W-1:0]     pct_r;
  logic [CNT_W+6:0]     pct_prod;

  assign can_load = !valid_r || out_bus.ready;

  // Scale used count to percent; divide by the block count is a shift.
  assign pct_prod = (CNT_W+7)'(rsp.used_blocks) * (CNT_W+7)'(PCT_FULL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status_r  <= rsp.status;
      granted_r <= rsp.granted_offset;
      pct_r     <= PCT_W'(pct_prod >> BLK_W);
    end
  end

  assign out_bus.valid          = valid_r;
  assign out_bus.status         = status_r;
  assign out_bus.granted_offset = granted_r;
  assign out_bus.usage_percent  = pct_r;

endmodule

// ===== design/block_map_allocator_core.sv =====
// First-fit, top-down block-map allocator for a pool of 1024 blocks of 32 bytes.
// One map entry per block lives in a single-port-write, one-read synchronous RAM
// and holds the length of the allocation owning the block (zero = free).
// After reset the block runs a clearing pass over the map, one entry per cycle,
// and in_bus.ready stays low until it is done. Items are handled one at a time:
// an allocate scans the map from the top block down at one entry per cycle
// (up to 1024 reads from the registered RAM read port) and then marks the run
// at one entry per cycle; a zero size or an oversize request goes straight to
// the result. A free reads the length at the addressed block and clears that
// many entries upward, not past the top block; it clears nothing when that
// block is already free or the offset lies beyond the pool. Each result
// beat carries status, granted offset (low 15 bits of the byte offset, zero
// unless the allocate succeeded) and pool usage in percent, rounded down. A
// result waits in an output register, and a new item is taken while it waits.
module block_map_allocator_core
  import bma_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  bma_in_if.sink     in_bus,
  bma_out_if.source  out_bus
);

  typedef enum logic [7:0] {
    ST_CLEAR    = 8'b0000_0001,
    ST_IDLE     = 8'b0000_0010,
    ST_SCAN     = 8'b0000_0100,
    ST_MARK     = 8'b0000_1000,
    ST_FREE_RD  = 8'b0001_0000,
    ST_FREE_LEN = 8'b0010_0000,
    ST_FREE_CLR = 8'b0100_0000,
    ST_RESP     = 8'b1000_0000
  } state_t;

  // Map storage.
  logic [CNT_W-1:0] map_mem [NUM_BLOCKS];
  logic [CNT_W-1:0] rd_data_r;
  logic             wr_en;
  logic [BLK_W-1:0] wr_addr;
  logic [CNT_W-1:0] wr_data;

  state_t           state_r, state_nxt;
  logic [BLK_W-1:0] issue_addr_r, issue_addr_nxt;
  logic             issue_on_r, issue_on_nxt;
  logic             rd_valid_r, rd_valid_nxt;
  logic [BLK_W-1:0] rd_blk_r, rd_blk_nxt;
  logic             rd_last_r, rd_last_nxt;
  logic [CNT_W-1:0] need_r, need_nxt;
  logic [CNT_W-1:0] run_r, run_nxt;
  logic [CNT_W-1:0] left_r, left_nxt;
  logic [BLK_W-1:0] base_r, base_nxt;
  logic [CNT_W-1:0] used_r, used_nxt;
  status_t          sts_r, sts_nxt;
  logic [OFS_W-1:0] gofs_r, gofs_nxt;

  logic             accept;
  logic             rsp_load;
  logic             can_load;
  logic [BYTES_W:0] need_wide;
  logic [CNT_W-1:0] run_step;
  rsp_t             rsp;

  assign in_bus.ready = (state_r == ST_IDLE);
  assign accept       = in_bus.valid && in_bus.ready;

  // Round byte size up to whole blocks.
  assign need_wide = ((BYTES_W+1)'(in_bus.request_bytes) + (BYTES_W+1)'(BLOCK_BYTES - 1))
                     >> BLOCK_SHIFT;

  assign run_step = (rd_data_r == '0) ? run_r + CNT_W'(1) : '0;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= map_mem[issue_addr_r];
  end

  always_comb begin
    state_nxt      = state_r;
    issue_addr_nxt = issue_addr_r;
    issue_on_nxt   = issue_on_r;
    rd_valid_nxt   = 1'b0;
    rd_blk_nxt     = rd_blk_r;
    rd_last_nxt    = rd_last_r;
    need_nxt       = need_r;
    run_nxt        = run_r;
    left_nxt       = left_r;
    base_nxt       = base_r;
    used_nxt       = used_r;
    sts_nxt        = sts_r;
    gofs_nxt       = gofs_r;
    wr_en          = 1'b0;
    wr_addr        = issue_addr_r;
    wr_data        = '0;
    rsp_load       = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        // Sweep zeros through the whole map.
        wr_en = 1'b1;
        if (issue_addr_r == BLK_W'(NUM_BLOCKS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          issue_addr_nxt = issue_addr_r + BLK_W'(1);
        end
      end

      ST_IDLE: begin
        if (accept) begin
          gofs_nxt = '0;
          sts_nxt  = STS_OK;
          if (in_bus.mode == MODE_FREE) begin
            if (32'(in_bus.release_offset) >= 32'(POOL_BYTES)) begin
              sts_nxt   = STS_RANGE;
              state_nxt = ST_RESP;
            end else begin
              issue_addr_nxt = BLK_W'(in_bus.release_offset >> BLOCK_SHIFT);
              state_nxt      = ST_FREE_RD;
            end
          end else if (in_bus.request_bytes == '0) begin
            sts_nxt   = STS_ZERO;
            state_nxt = ST_RESP;
          end else if (need_wide > (BYTES_W+1)'(NUM_BLOCKS)) begin
            sts_nxt   = STS_NO_RUN;
            state_nxt = ST_RESP;
          end else begin
            need_nxt       = CNT_W'(need_wide);
            run_nxt        = '0;
            issue_addr_nxt = BLK_W'(NUM_BLOCKS - 1);
            issue_on_nxt   = 1'b1;
            state_nxt      = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // Issue the next read downward; stop at block 0.
        if (issue_on_r) begin
          rd_valid_nxt = 1'b1;
          rd_blk_nxt   = issue_addr_r;
          rd_last_nxt  = (issue_addr_r == '0);
          if (issue_addr_r == '0) begin
            issue_on_nxt = 1'b0;
          end else begin
            issue_addr_nxt = issue_addr_r - BLK_W'(1);
          end
        end
        // Count the free run on returning data.
        if (rd_valid_r) begin
          run_nxt = run_step;
          if (run_step == need_r) begin
            rd_valid_nxt   = 1'b0;
            issue_on_nxt   = 1'b0;
            base_nxt       = rd_blk_r;
            issue_addr_nxt = rd_blk_r;
            left_nxt       = need_r;
            state_nxt      = ST_MARK;
          end else if (rd_last_r) begin
            rd_valid_nxt = 1'b0;
            issue_on_nxt = 1'b0;
            sts_nxt      = STS_NO_RUN;
            state_nxt    = ST_RESP;
          end
        end
      end

      ST_MARK: begin
        // Stamp the run length into every block of the run, low to high.
        wr_en   = 1'b1;
        wr_data = need_r;
        if (left_r == CNT_W'(1)) begin
          used_nxt  = used_r + need_r;
          gofs_nxt  = OFS_W'(32'(base_r) << BLOCK_SHIFT);
          sts_nxt   = STS_OK;
          state_nxt = ST_RESP;
        end else begin
          left_nxt       = left_r - CNT_W'(1);
          issue_addr_nxt = issue_addr_r + BLK_W'(1);
        end
      end

      ST_FREE_RD: begin
        state_nxt = ST_FREE_LEN;
      end

      ST_FREE_LEN: begin
        // Length at the addressed block sets the clear span.
        if (rd_data_r == '0) begin
          state_nxt = ST_RESP;
        end else begin
          left_nxt     = rd_data_r;
          issue_on_nxt = 1'b1;
          state_nxt    = ST_FREE_CLR;
        end
      end

      ST_FREE_CLR: begin
        if (issue_on_r) begin
          rd_valid_nxt = 1'b1;
          rd_blk_nxt   = issue_addr_r;
          rd_last_nxt  = (left_r == CNT_W'(1)) || (issue_addr_r == BLK_W'(NUM_BLOCKS - 1));
          if (rd_last_nxt) begin
            issue_on_nxt = 1'b0;
          end else begin
            left_nxt       = left_r - CNT_W'(1);
            issue_addr_nxt = issue_addr_r + BLK_W'(1);
          end
        end
        // Drop each entry; count down only those that were in use.
        if (rd_valid_r) begin
          wr_en   = 1'b1;
          wr_addr = rd_blk_r;
          if ((rd_data_r != '0) && (used_r != '0)) begin
            used_nxt = used_r - CNT_W'(1);
          end
          if (rd_last_r) begin
            rd_valid_nxt = 1'b0;
            state_nxt    = ST_RESP;
          end
        end
      end

      ST_RESP: begin
        // Hold until the output register frees up.
        if (can_load) begin
          rsp_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      issue_addr_r <= '0;
      issue_on_r   <= 1'b0;
      rd_valid_r   <= 1'b0;
      used_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      issue_addr_r <= issue_addr_nxt;
      issue_on_r   <= issue_on_nxt;
      rd_valid_r   <= rd_valid_nxt;
      used_r       <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_blk_r  <= rd_blk_nxt;
    rd_last_r <= rd_last_nxt;
    need_r    <= need_nxt;
    run_r     <= run_nxt;
    left_r    <= left_nxt;
    base_r    <= base_nxt;
    sts_r     <= sts_nxt;
    gofs_r    <= gofs_nxt;
  end

  assign rsp.status         = sts_r;
  assign rsp.granted_offset = gofs_r;
  assign rsp.used_blocks    = used_r;

  bma_result_reg u_result (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (rsp_load),
    .rsp      (rsp),
    .can_load (can_load),
    .out_bus  (out_bus)
  );

endmodule

// ===== tb/block_map_allocator_core_checker.sv =====
module block_map_allocator_core_checker
  import bma_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  bma_in_if    in_mon,
  bma_out_if   out_mon,
  output int   errors,
  output int   pending
);

  typedef struct packed {
    status_t          status;
    logic [OFS_W-1:0] granted_offset;
    logic [PCT_W-1:0] usage_percent;
  } grant_t;

  // Shadow of the block map and the used-block count.
  logic [CNT_W-1:0] shadow_map [NUM_BLOCKS];
  int               busy_blocks;
  grant_t           awaited_grants [$];

  task automatic report(input string what);
    $display("%0t mismatch: %s", $time, what);
    errors++;
  endtask

  // Apply one request to the shadow map and return the beat it should produce.
  function automatic grant_t apply_request(input logic mode,
                                           input logic [BYTES_W-1:0] req_bytes,
                                           input logic [BYTES_W-1:0] rel_offset);
    grant_t g;
    int     need;
    int     run;
    int     idx;
    int     len;
    g.status         = STS_OK;
    g.granted_offset = '0;
    if (mode == MODE_FREE) begin
      if (int'(rel_offset) >= POOL_BYTES) begin
        g.status = STS_RANGE;
      end else begin
        idx = int'(rel_offset) / BLOCK_BYTES;
        len = int'(shadow_map[idx]);
        for (int k = 0; k < len && idx + k < NUM_BLOCKS; k++) begin
          if (shadow_map[idx + k] != '0) begin
            shadow_map[idx + k] = '0;
            if (busy_blocks > 0) busy_blocks--;
          end
        end
      end
    end else if (req_bytes == '0) begin
      g.status = STS_ZERO;
    end else begin
      need     = (int'(req_bytes) + BLOCK_BYTES - 1) / BLOCK_BYTES;
      g.status = STS_NO_RUN;
      run      = 0;
      if (need <= NUM_BLOCKS) begin
        // top-down first fit; the scan ends at block 0
        for (int blk = NUM_BLOCKS - 1; blk >= 0; blk--) begin
          run = (shadow_map[blk] == '0) ? run + 1 : 0;
          if (run == need) begin
            for (int k = 0; k < need; k++) shadow_map[blk + k] = CNT_W'(need);
            busy_blocks     += need;
            g.granted_offset = OFS_W'(blk * BLOCK_BYTES);
            g.status         = STS_OK;
            break;
          end
        end
      end
    end
    g.usage_percent = PCT_W'((busy_blocks * PCT_FULL) / NUM_BLOCKS);
    return g;
  endfunction

  always @(posedge clk) begin : watch
    grant_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_BLOCKS; i++) shadow_map[i] = '0;
      busy_blocks = 0;
      awaited_grants.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (awaited_grants.size() == 0) begin
          report("result beat with nothing awaited");
        end else begin
          want = awaited_grants.pop_front();
          if (out_mon.status != want.status)
            report($sformatf("status %0d, want %0d", out_mon.status, want.status));
          if (out_mon.granted_offset != want.granted_offset)
            report($sformatf("granted_offset %0d, want %0d",
                             out_mon.granted_offset, want.granted_offset));
          if (out_mon.usage_percent != want.usage_percent)
            report($sformatf("usage_percent %0d, want %0d",
                             out_mon.usage_percent, want.usage_percent));
        end
      end
      if (in_mon.valid && in_mon.ready)
        awaited_grants.push_back(apply_request(in_mon.mode, in_mon.request_bytes,
                                               in_mon.release_offset));
    end
    pending <= awaited_grants.size();
  end

endmodule

// ===== tb/block_map_allocator_core_tb.sv =====
module block_map_allocator_core_tb;
  import bma_pkg::*;

  // Generous ceiling: ~290 items at a full-map scan plus both sides' longest
  // stalls, plus the clearing pass after reset, taken about three times over.
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int RANDOM_ITEMS = 266;
  localparam int DRAIN_CYCLES = 40;

  logic clk;
  logic rst_n;
  int   errors;
  int   pending_results;
  int   cycle_count;
  bit   calm;  // when set, neither side idles

  // Offsets handed out by the block, harvested so frees hit live runs.
  logic [OFS_W-1:0] live_offsets [$];

  bma_in_if  in_ch ();
  bma_out_if out_ch ();

  block_map_allocator_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_ch),
    .out_bus(out_ch)
  );

  block_map_allocator_core_checker grant_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_mon (in_ch),
    .out_mon(out_ch),
    .errors (errors),
    .pending(pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int pause_len();
    return calm ? 0 : $urandom_range(0, 18);
  endfunction

  // Collect nonzero granted offsets; an offset of zero is ambiguous with a
  // free beat, so skip it.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready && out_ch.status == STS_OK &&
        out_ch.granted_offset != '0)
      live_offsets.push_back(out_ch.granted_offset);
  end

  // Result side: after each beat hold ready low for a drawn number of cycles.
  initial begin : sink_side
    int hold;
    hold = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        hold = 0;
        out_ch.ready <= 1'b0;
      end else if (out_ch.valid && out_ch.ready) begin
        hold = pause_len();
        out_ch.ready <= (hold == 0);
      end else if (hold > 0) begin
        hold--;
        out_ch.ready <= (hold == 0);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Drive one request beat and hold it until taken. Valid stays high on
  // return so a back-to-back beat never drops it within one step.
  task automatic send_beat(input logic mode, input logic [BYTES_W-1:0] req_bytes,
                           input logic [BYTES_W-1:0] rel_offset);
    int gap;
    gap = pause_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.mode           <= mode;
    in_ch.request_bytes  <= req_bytes;
    in_ch.release_offset <= rel_offset;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic allocate(input int bytes);
    send_beat(1'b0, BYTES_W'(bytes), BYTES_W'($urandom_range(0, 16'hFFFF)));
  endtask

  task automatic release_at(input int offset);
    send_beat(MODE_FREE, BYTES_W'($urandom_range(0, 16'hFFFF)), BYTES_W'(offset));
  endtask

  // Stop sending until every awaited beat has come back.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending_results == 0);
  endtask

  initial begin : stimulus
    int pick;
    int idx;
    int ofs;
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.mode           <= 1'b0;
    in_ch.request_bytes  <= '0;
    in_ch.release_offset <= '0;
    calm = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: error codes and field extremes.
    allocate(0);                                  // zero size
    allocate(16'hFFFF);                           // far more blocks than the pool
    allocate(POOL_BYTES + 1);                     // one block too many
    release_at(POOL_BYTES);                       // first offset beyond the pool
    release_at(16'hFFFF);
    allocate(POOL_BYTES);                         // whole pool, usage 100
    allocate(1);                                  // pool full
    release_at(0);
    release_at(0);                                // free of a free block
    release_at(POOL_BYTES - 1);                   // last byte, free block
    // Free inside a run, reaching a neighbor allocation.
    allocate(1);                                  // top block
    allocate(BLOCK_BYTES + 1);                    // two blocks under it
    release_at((NUM_BLOCKS - 2) * BLOCK_BYTES + 5);
    release_at((NUM_BLOCKS - 3) * BLOCK_BYTES);
    // Clearing that would run past the top block.
    allocate(3 * BLOCK_BYTES);
    release_at((NUM_BLOCKS - 2) * BLOCK_BYTES);
    release_at((NUM_BLOCKS - 3) * BLOCK_BYTES);
    // Scan floor: only block 0 left, then nothing.
    allocate(POOL_BYTES - BLOCK_BYTES);
    allocate(BLOCK_BYTES);
    allocate(1);
    release_at(BLOCK_BYTES);
    release_at(0);
    allocate(100 * BLOCK_BYTES);
    release_at((NUM_BLOCKS - 100) * BLOCK_BYTES);

    drain();
    live_offsets.delete();

    // Random: mostly allocate/free pairs of live runs, with noise on top.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 30 == 0) calm = ($urandom_range(0, 3) == 0);
      if (i == RANDOM_ITEMS / 2) drain();
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        pick = $urandom_range(0, 99);
        if (pick < 60)      allocate($urandom_range(1, 256));
        else if (pick < 85) allocate($urandom_range(257, 4096));
        else if (pick < 93) allocate($urandom_range(4097, POOL_BYTES));
        else if (pick < 96) allocate(0);
        else                allocate($urandom_range(POOL_BYTES + 1, 16'hFFFF));
      end else if (pick < 85 && live_offsets.size() > 0) begin
        idx = $urandom_range(0, live_offsets.size() - 1);
        ofs = int'(live_offsets[idx]);
        live_offsets.delete(idx);
        // now and then land inside the run or just past its start
        if ($urandom_range(0, 3) == 0) ofs += $urandom_range(1, 3 * BLOCK_BYTES);
        release_at(ofs < POOL_BYTES ? ofs : POOL_BYTES - 1);
      end else if (pick < 95) begin
        release_at($urandom_range(0, POOL_BYTES - 1));
      end else begin
        release_at($urandom_range(POOL_BYTES, 16'hFFFF));
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_results == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/bma_pkg.sv
design/bma_in_if.sv
design/bma_out_if.sv
design/bma_result_reg.sv
design/block_map_allocator_core.sv
tb/block_map_allocator_core_checker.sv
tb/block_map_allocator_core_tb.sv
